/* src/k4_with_directed_edge_detect_top_macros.svh */
// Assertion macros shared by the edge-detect block.
`ifndef K4_WITH_DIRECTED_EDGE_DETECT_TOP_MACROS_SVH
`define K4_WITH_DIRECTED_EDGE_DETECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define K4DD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("k4dd same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define K4DD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("k4dd next-cycle check failed");

`endif

/* src/k4dd_pkg.sv */
// Shared constants, command and status types, and helpers for the edge-detect block.
package k4dd_pkg;

    // Default sizes of the graph store.
    localparam int VERTEX_COUNT_DEF  = 16;
    localparam int EDGE_CAPACITY_DEF = 128;

    // Field widths fixed by the item format.
    localparam int MASK_W   = 16;
    localparam int VID_W    = 4;
    localparam int ACT_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic add;
        logic query_start;
        logic scan;
        logic collect;
        logic scan_clear;
        logic rd_a;
        logic rd_b;
        logic rd_c;
        logic cap_a;
        logic cap_b;
        logic cap_c;
        logic pair_clear;
        logic advance;
        logic load_result;
        logic result_found;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic enough;
        logic hit;
        logic last_triple;
        logic out_free;
    } t_status;

    // Index of the lowest set bit; zero for an empty mask.
    function automatic logic [VID_W-1:0] lowest_bit(input logic [MASK_W-1:0] m);
        logic [VID_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = VID_W'(i);
            end
        end
        return idx;
    endfunction

    // One-hot mask of a vertex number.
    function automatic logic [MASK_W-1:0] vertex_bit(input logic [VID_W-1:0] v);
        return MASK_W'(1) << v;
    endfunction

endpackage

/* src/k4_with_directed_edge_detect_top.sv */
// Top level of the K4-through-a-vertex detector with directed edge check.
//
// Input channel (i_s_*): one transaction is one action. tuser carries the
// action code (clear, add edge, query vertex) and the directed flag; tdata
// carries the edge's vertex mask and the query vertex. Clears and adds
// produce no result, so they can stream back to back.
// Adds beyond the edge capacity are dropped and set the overflow flag.
// A query produces one output transaction (o_m_*) with the K4 answer and the
// overflow flag. A query scans the edge memory once for neighbour collection
// and once per neighbour triple; a hit ends the walk early.
// No new transaction is accepted while a query runs. The result sits in an
// output register; adds and clears are still accepted while it waits, but a
// following query holds its result until the receiver takes the old one.
// Reset empties the edge store and clears the overflow flag and output valid.
`include "k4_with_directed_edge_detect_top_macros.svh"

module k4_with_directed_edge_detect_top #(
    parameter int VERTEX_COUNT  = k4dd_pkg::VERTEX_COUNT_DEF,
    parameter int EDGE_CAPACITY = k4dd_pkg::EDGE_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [15:0] edge_vertices, [19:16] query_vertex, [23:20] zero
    input  logic [k4dd_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [1:0] action, [2] edge_is_directed
    input  logic [k4dd_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] found_k4, [1] store_overflowed, [7:2] zero
    output logic [k4dd_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    k4dd_pkg::t_cmd                    w_cmd;
    k4dd_pkg::t_status                 w_status;
    logic [k4dd_pkg::ACT_W-1:0]        w_action;
    logic                              w_found;
    logic                              w_ovf;
    logic                              w_query_accept;

    // Field unpacking of the input transaction.
    assign w_action = i_s_tuser[k4dd_pkg::ACT_W-1:0];
    assign w_query_accept = i_s_tvalid && o_s_tready && (w_action == k4dd_pkg::ACT_QUERY);

    k4dd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (w_action),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    k4dd_datapath #(
        .VERTEX_COUNT  (VERTEX_COUNT),
        .EDGE_CAPACITY (EDGE_CAPACITY)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_edge_vertices    (i_s_tdata[k4dd_pkg::MASK_W-1:0]),
        .i_edge_is_directed (i_s_tuser[k4dd_pkg::ACT_W]),
        .i_query_vertex     (i_s_tdata[k4dd_pkg::MASK_W +: k4dd_pkg::VID_W]),
        .o_m_tvalid         (o_m_tvalid),
        .i_m_tready         (i_m_tready),
        .o_found_k4         (w_found),
        .o_store_overflowed (w_ovf)
    );

    // Output packing.
    assign o_m_tdata = {{(k4dd_pkg::M_TDATA_W - 2){1'b0}}, w_ovf, w_found};

    // A result is only loaded into a free output register.
    `K4DD_ASSERT_NOW(a_load_into_free, i_clk, i_rst_n, w_cmd.load_result, w_status.out_free)
    // A loaded result shows on the output in the next cycle.
    `K4DD_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.load_result, o_m_tvalid)
    // An accepted query blocks further input while it runs.
    `K4DD_ASSERT_NEXT(a_query_blocks, i_clk, i_rst_n, w_query_accept, !o_s_tready)
    // Edge writes never overlap a memory scan.
    `K4DD_ASSERT_NOW(a_add_no_scan, i_clk, i_rst_n, w_cmd.add, !w_cmd.scan)

endmodule

/* src/k4dd_ctrl.sv */
// Controller state machine that sequences edge adds, clears and K4 queries.
module k4dd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [k4dd_pkg::ACT_W-1:0]  i_action,
    input  k4dd_pkg::t_status           i_status,
    output k4dd_pkg::t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COLLECT,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_CAP_C,
        S_PAIRS,
        S_EVAL,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_found;
    logic   n_found;
    logic   w_accept;

    // Input transactions are taken only between queries.
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        k4dd_pkg::ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        k4dd_pkg::ACT_ADD: begin
                            o_cmd.add = 1'b1;
                        end
                        k4dd_pkg::ACT_QUERY: begin
                            o_cmd.query_start = 1'b1;
                            o_cmd.scan_clear  = 1'b1;
                            n_state           = S_COLLECT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COLLECT: begin
                o_cmd.scan    = 1'b1;
                o_cmd.collect = 1'b1;
                if (i_status.scan_done) begin
                    if (i_status.enough) begin
                        n_state = S_RD_A;
                    end else begin
                        n_found = 1'b0;
                        n_state = S_FINISH;
                    end
                end
            end
            S_RD_A: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RD_B;
            end
            S_RD_B: begin
                o_cmd.cap_a = 1'b1;
                o_cmd.rd_b  = 1'b1;
                n_state     = S_RD_C;
            end
            S_RD_C: begin
                o_cmd.cap_b = 1'b1;
                o_cmd.rd_c  = 1'b1;
                n_state     = S_CAP_C;
            end
            S_CAP_C: begin
                o_cmd.cap_c      = 1'b1;
                o_cmd.scan_clear = 1'b1;
                o_cmd.pair_clear = 1'b1;
                n_state          = S_PAIRS;
            end
            S_PAIRS: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.hit) begin
                    n_found = 1'b1;
                    n_state = S_FINISH;
                end else if (i_status.last_triple) begin
                    n_found = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD_A;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_result  = 1'b1;
                    o_cmd.result_found = r_found;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered query answer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

endmodule

/* src/k4dd_datapath.sv */
// Datapath: edge memory, neighbour memory, triple indices, pair flags and result register.
module k4dd_datapath #(
    parameter int VERTEX_COUNT  = k4dd_pkg::VERTEX_COUNT_DEF,
    parameter int EDGE_CAPACITY = k4dd_pkg::EDGE_CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  k4dd_pkg::t_cmd                i_cmd,
    output k4dd_pkg::t_status             o_status,
    input  logic [k4dd_pkg::MASK_W-1:0]   i_edge_vertices,
    input  logic                          i_edge_is_directed,
    input  logic [k4dd_pkg::VID_W-1:0]    i_query_vertex,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic                          o_found_k4,
    output logic                          o_store_overflowed
);

    localparam int EAW = $clog2(EDGE_CAPACITY);
    localparam int ECW = $clog2(EDGE_CAPACITY + 1);
    localparam int VAW = $clog2(VERTEX_COUNT);
    localparam int VCW = $clog2(VERTEX_COUNT + 1);
    localparam int MW  = k4dd_pkg::MASK_W;
    localparam int IW  = k4dd_pkg::VID_W;

    // Edge store: directed bit above the vertex mask.
    logic [MW:0]       r_edge_mem [EDGE_CAPACITY];
    logic [MW:0]       r_edata;
    logic [ECW-1:0]    r_held;
    logic              r_ovf;
    logic [ECW-1:0]    r_eidx;
    logic              r_epend;
    logic [MW-1:0]     r_vbit;

    // Neighbour list: vertex number above the directed bit.
    logic [IW:0]       r_nb_mem [VERTEX_COUNT];
    logic [IW:0]       r_nb_q;
    logic [VCW-1:0]    r_nb_count;
    logic [VCW-1:0]    r_a;
    logic [VCW-1:0]    r_b;
    logic [VCW-1:0]    r_c;
    logic [IW:0]       r_va;
    logic [IW:0]       r_vb;
    logic [IW:0]       r_vc;

    // Pair match flags for the current triple.
    logic r_h_ab, r_h_bc, r_h_ca;
    logic r_d_ab, r_d_bc, r_d_ca;

    // Result register.
    logic r_out_valid;
    logic r_out_found;
    logic r_out_ovf;

    logic            w_full;
    logic            w_rd_en;
    logic [MW-1:0]   w_emask;
    logic            w_edir;
    logic [MW-1:0]   w_other;
    logic            w_nb_wr;
    logic            w_pair_upd;
    logic [VCW-1:0]  w_nb_idx;
    logic [MW-1:0]   w_p_ab;
    logic [MW-1:0]   w_p_bc;
    logic [MW-1:0]   w_p_ca;
    logic            w_c_more;
    logic            w_b_more;
    logic            w_a_more;

    assign w_full  = (r_held >= ECW'(EDGE_CAPACITY));
    assign w_rd_en = i_cmd.scan && (r_eidx < r_held);
    assign w_emask = r_edata[MW-1:0];
    assign w_edir  = r_edata[MW];
    assign w_other = w_emask & ~r_vbit;

    // A stored edge through the query vertex yields its lowest other vertex.
    assign w_nb_wr = i_cmd.scan && i_cmd.collect && r_epend && (|(w_emask & r_vbit))
                     && (|w_other) && (r_nb_count < VCW'(VERTEX_COUNT));
    assign w_pair_upd = i_cmd.scan && !i_cmd.collect && r_epend;

    // Pair masks of the current triple.
    assign w_p_ab = k4dd_pkg::vertex_bit(r_va[IW:1]) | k4dd_pkg::vertex_bit(r_vb[IW:1]);
    assign w_p_bc = k4dd_pkg::vertex_bit(r_vb[IW:1]) | k4dd_pkg::vertex_bit(r_vc[IW:1]);
    assign w_p_ca = k4dd_pkg::vertex_bit(r_vc[IW:1]) | k4dd_pkg::vertex_bit(r_va[IW:1]);

    // Triple index stepping conditions.
    assign w_c_more = (r_c + VCW'(1)) < r_nb_count;
    assign w_b_more = (r_b + VCW'(2)) < r_nb_count;
    assign w_a_more = (r_a + VCW'(3)) < r_nb_count;

    // Neighbour read address.
    always_comb begin
        if (i_cmd.rd_a) begin
            w_nb_idx = r_a;
        end else if (i_cmd.rd_b) begin
            w_nb_idx = r_b;
        end else begin
            w_nb_idx = r_c;
        end
    end

    // Status back to the controller.
    assign o_status.scan_done   = !r_epend && !(r_eidx < r_held);
    assign o_status.enough      = (r_nb_count >= VCW'(3));
    assign o_status.hit         = r_h_ab && r_h_bc && r_h_ca &&
                                  (r_d_ab || r_d_bc || r_d_ca ||
                                   r_va[0] || r_vb[0] || r_vc[0]);
    assign o_status.last_triple = !w_c_more && !w_b_more && !w_a_more;
    assign o_status.out_free    = !r_out_valid || i_m_tready;

    // Edge memory: one write port for adds, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !w_full) begin
            r_edge_mem[r_held[EAW-1:0]] <= {i_edge_is_directed, i_edge_vertices};
        end
        if (w_rd_en) begin
            r_edata <= r_edge_mem[r_eidx[EAW-1:0]];
        end
    end

    // Neighbour memory: written while collecting, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_nb_wr) begin
            r_nb_mem[r_nb_count[VAW-1:0]] <= {k4dd_pkg::lowest_bit(w_other), w_edir};
        end
        if (i_cmd.rd_a || i_cmd.rd_b || i_cmd.rd_c) begin
            r_nb_q <= r_nb_mem[w_nb_idx[VAW-1:0]];
        end
    end

    // Fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.clear) begin
            r_held <= '0;
            r_ovf  <= 1'b0;
        end else if (i_cmd.add) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_held <= r_held + ECW'(1);
            end
        end
    end

    // Edge scan address and read pending flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eidx  <= '0;
            r_epend <= 1'b0;
        end else if (i_cmd.scan_clear) begin
            r_eidx  <= '0;
            r_epend <= 1'b0;
        end else if (i_cmd.scan) begin
            r_epend <= w_rd_en;
            if (w_rd_en) begin
                r_eidx <= r_eidx + ECW'(1);
            end
        end
    end

    // Neighbour count and triple indices.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb_count <= '0;
            r_a        <= '0;
            r_b        <= '0;
            r_c        <= '0;
        end else if (i_cmd.query_start) begin
            r_nb_count <= '0;
            r_a        <= VCW'(0);
            r_b        <= VCW'(1);
            r_c        <= VCW'(2);
        end else begin
            if (w_nb_wr) begin
                r_nb_count <= r_nb_count + VCW'(1);
            end
            if (i_cmd.advance) begin
                if (w_c_more) begin
                    r_c <= r_c + VCW'(1);
                end else if (w_b_more) begin
                    r_b <= r_b + VCW'(1);
                    r_c <= r_b + VCW'(2);
                end else begin
                    r_a <= r_a + VCW'(1);
                    r_b <= r_a + VCW'(2);
                    r_c <= r_a + VCW'(3);
                end
            end
        end
    end

    // Query vertex mask and captured triple entries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_vbit <= k4dd_pkg::vertex_bit(i_query_vertex);
        end
        if (i_cmd.cap_a) begin
            r_va <= r_nb_q;
        end
        if (i_cmd.cap_b) begin
            r_vb <= r_nb_q;
        end
        if (i_cmd.cap_c) begin
            r_vc <= r_nb_q;
        end
    end

    // Pair flags: an edge matches at most one pair, the last match decides.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_clear) begin
            r_h_ab <= 1'b0;
            r_h_bc <= 1'b0;
            r_h_ca <= 1'b0;
            r_d_ab <= 1'b0;
            r_d_bc <= 1'b0;
            r_d_ca <= 1'b0;
        end else if (w_pair_upd) begin
            if (w_emask == w_p_ab) begin
                r_h_ab <= 1'b1;
                r_d_ab <= w_edir;
            end else if (w_emask == w_p_bc) begin
                r_h_bc <= 1'b1;
                r_d_bc <= w_edir;
            end else if (w_emask == w_p_ca) begin
                r_h_ca <= 1'b1;
                r_d_ca <= w_edir;
            end
        end
    end

    // Result register toward the output channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_found <= i_cmd.result_found;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_m_tvalid         = r_out_valid;
    assign o_found_k4         = r_out_found;
    assign o_store_overflowed = r_out_ovf;

endmodule

/* bench/k4_with_directed_edge_detect_top_tb.sv */
// Self-checking testbench for the K4-through-a-vertex detector with directed edge check.
module k4_with_directed_edge_detect_top_tb;

    // Field widths of the transactions.
    localparam int ACT_W     = k4dd_pkg::ACT_W;
    localparam int MASK_W    = k4dd_pkg::MASK_W;
    localparam int VID_W     = k4dd_pkg::VID_W;
    localparam int S_TDATA_W = k4dd_pkg::S_TDATA_W;
    localparam int S_TUSER_W = k4dd_pkg::S_TUSER_W;
    localparam int M_TDATA_W = k4dd_pkg::M_TDATA_W;

    // The one action code that the block ignores.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    // Sizes of the block under test.
    localparam int NB_MAX  = k4dd_pkg::VERTEX_COUNT_DEF;
    localparam int EDGE_MAX = k4dd_pkg::EDGE_CAPACITY_DEF;

    // Stimulus budget: random graphs stop here, and idling stops a little earlier.
    localparam int RANDOM_END = 1000;
    localparam int QUIET_FROM = 850;

    // One expected query answer.
    typedef struct packed {
        logic found;
        logic ovf;
    } t_k4_answer;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [15:0] edge_vertices, [19:16] query_vertex, [23:20] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [1:0] action, [2] edge_is_directed
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] found_k4, [1] store_overflowed, [7:2] zero
    logic [M_TDATA_W-1:0] m_tdata;

    // Copy of the graph store kept by the predictor.
    logic [MASK_W-1:0] graph_mask [EDGE_MAX];
    logic              graph_dir  [EDGE_MAX];
    int                graph_held = 0;
    logic              graph_ovf  = 1'b0;

    // Answers still owed by the block, oldest first.
    t_k4_answer answers_due [$];

    // Run controls and bookkeeping.
    logic gaps_on    = 1'b1;
    logic sink_hold  = 1'b0;
    int   stall_left = 0;
    int   mismatches = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   hits_seen    = 0;
    int   ovf_seen     = 0;

    k4_with_directed_edge_detect_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Hard limit on the run time.
    initial begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Searches the stored graph for a K4 through vertex v with a directed edge.
    function automatic logic k4_through(input logic [VID_W-1:0] v);
        logic [MASK_W-1:0] vbit, other, m, p_ab, p_bc, p_ca;
        logic [VID_W-1:0]  nb_vtx [NB_MAX];
        logic              nb_dir [NB_MAX];
        logic              h_ab, h_bc, h_ca, d_ab, d_bc, d_ca;
        int                nb_count;
        vbit = MASK_W'(1) << v;
        nb_count = 0;
        // Collect the lowest other vertex of every edge through v, up to the limit.
        for (int e = 0; e < graph_held; e++) begin
            m = graph_mask[e];
            other = m & ~vbit;
            if ((m & vbit) != '0 && other != '0 && nb_count < NB_MAX) begin
                for (int i = MASK_W - 1; i >= 0; i--) begin
                    if (other[i]) begin
                        nb_vtx[nb_count] = VID_W'(i);
                    end
                end
                nb_dir[nb_count] = graph_dir[e];
                nb_count++;
            end
        end
        // Every neighbour triple needs all three pair edges; the last matching edge
        // decides the directed bit of a pair.
        for (int a = 0; a < nb_count; a++) begin
            for (int b = a + 1; b < nb_count; b++) begin
                for (int c = b + 1; c < nb_count; c++) begin
                    p_ab = (MASK_W'(1) << nb_vtx[a]) | (MASK_W'(1) << nb_vtx[b]);
                    p_bc = (MASK_W'(1) << nb_vtx[b]) | (MASK_W'(1) << nb_vtx[c]);
                    p_ca = (MASK_W'(1) << nb_vtx[c]) | (MASK_W'(1) << nb_vtx[a]);
                    {h_ab, h_bc, h_ca, d_ab, d_bc, d_ca} = '0;
                    for (int e = 0; e < graph_held; e++) begin
                        if (graph_mask[e] == p_ab) begin
                            h_ab = 1'b1;
                            d_ab = graph_dir[e];
                        end else if (graph_mask[e] == p_bc) begin
                            h_bc = 1'b1;
                            d_bc = graph_dir[e];
                        end else if (graph_mask[e] == p_ca) begin
                            h_ca = 1'b1;
                            d_ca = graph_dir[e];
                        end
                    end
                    if (h_ab && h_bc && h_ca &&
                        (d_ab || d_bc || d_ca || nb_dir[a] || nb_dir[b] || nb_dir[c])) begin
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted transaction to the predicted graph.
    task automatic apply_action(input logic [ACT_W-1:0] act, input logic [MASK_W-1:0] mask,
                                input logic dir, input logic [VID_W-1:0] vtx);
        t_k4_answer ans;
        case (act)
            k4dd_pkg::ACT_CLEAR: begin
                graph_held = 0;
                graph_ovf = 1'b0;
            end
            k4dd_pkg::ACT_ADD: begin
                if (graph_held < EDGE_MAX) begin
                    graph_mask[graph_held] = mask;
                    graph_dir[graph_held] = dir;
                    graph_held++;
                end else begin
                    graph_ovf = 1'b1;
                end
            end
            k4dd_pkg::ACT_QUERY: begin
                ans.found = k4_through(vtx);
                ans.ovf = graph_ovf;
                answers_due.push_back(ans);
            end
            default: begin
            end
        endcase
    endtask

    // Offers one transaction, with an optional idle burst first, and waits for it
    // to be taken.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [MASK_W-1:0] mask,
                             input logic dir, input logic [VID_W-1:0] vtx);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, vtx, mask};
        s_tuser  <= {dir, act};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        apply_action(act, mask, dir, vtx);
        if (act != ACT_UNUSED) begin
            items_sent++;
        end
    endtask

    // Drops the valid so that no stale transaction is offered.
    task automatic sender_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Sender pauses until every owed answer has come back.
    task automatic wait_drain();
        sender_idle();
        do @(posedge clk); while (answers_due.size() != 0);
    endtask

    // Holds the receiver off for the length that its argument gives.
    task automatic hold_sink(input int cycles);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold = 1'b0;
    endtask

    task automatic send_clear();
        send_item(k4dd_pkg::ACT_CLEAR, MASK_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), VID_W'($urandom_range(0, 15)));
    endtask

    task automatic send_add(input logic [MASK_W-1:0] mask, input logic dir);
        send_item(k4dd_pkg::ACT_ADD, mask, dir, VID_W'($urandom_range(0, 15)));
    endtask

    task automatic send_query(input logic [VID_W-1:0] vtx);
        send_item(k4dd_pkg::ACT_QUERY, MASK_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), vtx);
    endtask

    task automatic note_mismatch(input string what, input int exp_val, input int got_val);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH at %0t: %s, expected %0d, got %0d", $time, what, exp_val, got_val);
        end
    endtask

    // Receiver: random stall bursts, plus the long hold-off when requested.
    always @(negedge clk) begin
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 17);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compares each output transaction with the oldest owed answer.
    always @(posedge clk) begin : check_results
        t_k4_answer due;
        if (rst_n && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                note_mismatch("result with no query pending (tdata shown)", 0, int'(m_tdata));
            end else begin
                due = answers_due.pop_front();
                results_seen++;
                if (due.found) hits_seen++;
                if (due.ovf) ovf_seen++;
                if (m_tdata[0] !== due.found) begin
                    note_mismatch("found_k4", int'(due.found), int'(m_tdata[0]));
                end
                if (m_tdata[1] !== due.ovf) begin
                    note_mismatch("store_overflowed", int'(due.ovf), int'(m_tdata[1]));
                end
            end
        end
    end

    // Empty graph, one K4 with and without a directed edge, odd masks, ignored action.
    task automatic test_directed_basics();
        send_query(4'd15);
        send_item(ACT_UNUSED, 16'hFFFF, 1'b1, 4'd15);
        send_add(16'h0003, 1'b0);
        send_add(16'h0006, 1'b0);
        send_add(16'h000C, 1'b0);
        send_add(16'h0009, 1'b0);
        send_add(16'h0005, 1'b0);
        send_add(16'h000A, 1'b0);
        send_query(4'd0);
        // A repeated pair: the later, directed copy decides.
        send_add(16'h0006, 1'b1);
        send_query(4'd3);
        // Edge holding only the query vertex, edge with every vertex, empty edge.
        send_add(16'h0001, 1'b1);
        send_add(16'hFFFF, 1'b1);
        send_add(16'h0000, 1'b0);
        send_query(4'd0);
        send_query(4'd15);
        send_add(16'h8001, 1'b0);
        send_query(4'd15);
        send_clear();
        send_query(4'd0);
        wait_drain();
    endtask

    // Fills the edge store exactly, then goes past it.
    task automatic test_store_overflow();
        send_clear();
        send_add(16'h3000, 1'b0);
        send_add(16'h5000, 1'b0);
        send_add(16'h9000, 1'b0);
        send_add(16'h6000, 1'b0);
        send_add(16'hA000, 1'b0);
        send_add(16'hC000, 1'b1);
        // Fillers stay off the K4's vertices so the queries stay short.
        repeat (EDGE_MAX - 6) begin
            send_add(MASK_W'($urandom_range(1, 12'hFFF)), 1'($urandom_range(0, 1)));
        end
        send_query(4'd15);
        send_add(16'hC000, 1'b0);
        send_query(4'd12);
        send_add(16'hFFFF, 1'b1);
        send_query(4'd13);
        send_clear();
        send_query(4'd15);
        wait_drain();
    endtask

    // More edges through the vertex than the neighbour list holds.
    task automatic test_neighbour_limit();
        send_clear();
        for (int n = 1; n <= 13; n++) send_add(MASK_W'(1) | (MASK_W'(1) << n), 1'b0);
        for (int n = 1; n <= 3; n++) send_add(MASK_W'(1) | (MASK_W'(1) << n), 1'b0);
        // These two fall beyond the list, so their K4 must not be seen.
        send_add(16'h4001, 1'b1);
        send_add(16'h8001, 1'b1);
        send_add(16'h6000, 1'b0);
        send_add(16'hC000, 1'b0);
        send_add(16'hA000, 1'b0);
        send_query(4'd0);
        send_clear();
        for (int n = 1; n <= 15; n++) send_add(MASK_W'(1) | (MASK_W'(1) << n), 1'(n == 14));
        send_add(16'h6000, 1'b0);
        send_add(16'hC000, 1'b0);
        send_add(16'hA000, 1'b0);
        send_query(4'd0);
        send_query(4'd14);
        wait_drain();
    endtask

    // Receiver held off long enough that a second query stalls the input.
    task automatic test_output_backpressure();
        send_clear();
        send_add(16'h0030, 1'b0);
        send_add(16'h0050, 1'b0);
        send_add(16'h0090, 1'b1);
        send_add(16'h0060, 1'b0);
        send_add(16'h00A0, 1'b0);
        send_add(16'h00C0, 1'b0);
        fork
            hold_sink(400);
        join_none
        send_query(4'd4);
        send_add(16'h0110, 1'b0);
        send_add(16'h0210, 1'b0);
        send_query(4'd5);
        send_query(4'd6);
        send_add(16'h0300, 1'b1);
        send_query(4'd7);
        send_clear();
        send_query(4'd4);
        wait_drain();
    endtask

    // Random small graphs, mostly built around a four-vertex clique.
    task automatic test_random_graphs();
        logic [VID_W-1:0]  quad [4];
        logic [MASK_W-1:0] pairs [6];
        logic [MASK_W-1:0] swap_mask, used;
        logic [VID_W-1:0]  q_vtx;
        int                pick, idx, n_edges, n_extra, n_query;
        while (items_sent < RANDOM_END) begin
            gaps_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 4) != 0);
            if (graph_held > 8 || $urandom_range(0, 3) != 0) begin
                send_clear();
            end
            // Four distinct vertices and their six pair edges in random order.
            used = '0;
            for (int i = 0; i < 4; i++) begin
                do pick = $urandom_range(0, 15); while (used[pick]);
                used[pick] = 1'b1;
                quad[i] = VID_W'(pick);
            end
            idx = 0;
            for (int i = 0; i < 4; i++) begin
                for (int j = i + 1; j < 4; j++) begin
                    pairs[idx] = (MASK_W'(1) << quad[i]) | (MASK_W'(1) << quad[j]);
                    idx++;
                end
            end
            for (int i = 5; i > 0; i--) begin
                pick = $urandom_range(0, i);
                swap_mask = pairs[i];
                pairs[i] = pairs[pick];
                pairs[pick] = swap_mask;
            end
            // Now and then the clique is left incomplete.
            n_edges = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 5) : 6;
            for (int i = 0; i < n_edges; i++) begin
                send_add(pairs[i], 1'($urandom_range(0, 6) == 0));
                if ($urandom_range(0, 11) == 0) begin
                    send_query(quad[$urandom_range(0, 3)]);
                end
            end
            // Extra edges: spurs off the clique and plain noise.
            n_extra = $urandom_range(0, 3);
            for (int i = 0; i < n_extra; i++) begin
                case ($urandom_range(0, 3))
                    0: send_add((MASK_W'(1) << quad[$urandom_range(0, 3)]) |
                                (MASK_W'(1) << $urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                    1: send_add(MASK_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                    2: send_add(MASK_W'(1) << $urandom_range(0, 15), 1'($urandom_range(0, 1)));
                    default: send_add(($urandom_range(0, 1) == 0) ? '0 :
                                      ((MASK_W'(1) << quad[0]) | (MASK_W'(1) << quad[1]) |
                                       (MASK_W'(1) << $urandom_range(0, 15))),
                                      1'($urandom_range(0, 1)));
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                send_item(ACT_UNUSED, MASK_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                          VID_W'($urandom_range(0, 15)));
            end
            n_query = $urandom_range(1, 3);
            for (int i = 0; i < n_query; i++) begin
                q_vtx = ($urandom_range(0, 3) != 0) ? quad[$urandom_range(0, 3)] :
                                                      VID_W'($urandom_range(0, 15));
                send_query(q_vtx);
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_basics();
        test_store_overflow();
        test_neighbour_limit();
        test_output_backpressure();
        test_random_graphs();
        gaps_on = 1'b0;
        wait_drain();
        // Give any stray output a chance to show up.
        repeat (100) @(posedge clk);
        $display("Sent %0d clear, add and query transactions; checked %0d query results.",
                 items_sent, results_seen);
        $display("Results with a K4 found: %0d, with the overflow flag set: %0d.",
                 hits_seen, ovf_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
